// ===== hdl/rptg_pkg.sv =====
// shared types, register indexes and reset values for the rgb panel timing generator
// no dependencies; used by every rptg module and the top level
package rptg_pkg;

  localparam int unsigned CntW     = 12;  // column and row counters
  localparam int unsigned PorchW   = 8;   // porch and sync widths
  localparam int unsigned ActW     = 11;  // active pixel and line counts
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 11;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegHFrontPorch = 3'd0;
  localparam logic [CfgIdxW-1:0] RegHSyncWidth  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegHBackPorch  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegHActive     = 3'd3;
  localparam logic [CfgIdxW-1:0] RegVSyncWidth  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegVBackPorch  = 3'd5;
  localparam logic [CfgIdxW-1:0] RegVActive     = 3'd6;
  localparam logic [CfgIdxW-1:0] RegVFrontPorch = 3'd7;

  // reset values
  localparam logic [PorchW-1:0] RstHFrontPorch = 8'd4;
  localparam logic [PorchW-1:0] RstHSyncWidth  = 8'd16;
  localparam logic [PorchW-1:0] RstHBackPorch  = 8'd30;
  localparam logic [ActW-1:0]   RstHActive     = 11'd480;
  localparam logic [PorchW-1:0] RstVSyncWidth  = 8'd8;
  localparam logic [PorchW-1:0] RstVBackPorch  = 8'd5;
  localparam logic [ActW-1:0]   RstVActive     = 11'd480;
  localparam logic [PorchW-1:0] RstVFrontPorch = 8'd5;

  // region boundaries derived from the registers
  typedef struct packed {
    logic [7:0]      h_sync_start;
    logic [8:0]      h_sync_end;
    logic [9:0]      h_act_start;
    logic [CntW-1:0] h_act_end;
    logic [CntW-1:0] h_last;
    logic [7:0]      v_sync_end;
    logic [8:0]      v_act_start;
    logic [CntW-1:0] v_act_end;
    logic [CntW-1:0] v_last;
  } timing_t;

  // one tick held between the counter stage and the decode stage
  typedef struct packed {
    logic [CntW-1:0] col;
    logic [CntW-1:0] row;
    logic            frame_end;
    logic            red;
    logic            green;
    logic            blue;
  } tick_t;

  // one result beat
  typedef struct packed {
    logic hsync_n;
    logic vsync_n;
    logic data_enable;
    logic red;
    logic green;
    logic blue;
    logic pixel_strobe;
    logic frame_last;
  } pixel_t;

endpackage

// ===== hdl/rptg_regs.sv =====
// timing registers and the region boundaries derived from them
// depends on rptg_pkg
module rptg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rptg_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [rptg_pkg::CfgDataW-1:0]    cfg_data_i,
  output rptg_pkg::timing_t                timing_o
);

  logic [rptg_pkg::PorchW-1:0] hfp_q, hsw_q, hbp_q, vsw_q, vbp_q, vfp_q;
  logic [rptg_pkg::ActW-1:0]   hact_q, vact_q;
  logic [rptg_pkg::CntW-1:0]   h_total, v_total;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hfp_q  <= rptg_pkg::RstHFrontPorch;
      hsw_q  <= rptg_pkg::RstHSyncWidth;
      hbp_q  <= rptg_pkg::RstHBackPorch;
      hact_q <= rptg_pkg::RstHActive;
      vsw_q  <= rptg_pkg::RstVSyncWidth;
      vbp_q  <= rptg_pkg::RstVBackPorch;
      vact_q <= rptg_pkg::RstVActive;
      vfp_q  <= rptg_pkg::RstVFrontPorch;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rptg_pkg::RegHFrontPorch: hfp_q  <= cfg_data_i[rptg_pkg::PorchW-1:0];
        rptg_pkg::RegHSyncWidth:  hsw_q  <= cfg_data_i[rptg_pkg::PorchW-1:0];
        rptg_pkg::RegHBackPorch:  hbp_q  <= cfg_data_i[rptg_pkg::PorchW-1:0];
        rptg_pkg::RegHActive:     hact_q <= cfg_data_i[rptg_pkg::ActW-1:0];
        rptg_pkg::RegVSyncWidth:  vsw_q  <= cfg_data_i[rptg_pkg::PorchW-1:0];
        rptg_pkg::RegVBackPorch:  vbp_q  <= cfg_data_i[rptg_pkg::PorchW-1:0];
        rptg_pkg::RegVActive:     vact_q <= cfg_data_i[rptg_pkg::ActW-1:0];
        rptg_pkg::RegVFrontPorch: vfp_q  <= cfg_data_i[rptg_pkg::PorchW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    timing_o.h_sync_start = hfp_q;
    timing_o.h_sync_end   = 9'(hfp_q) + 9'(hsw_q);
    timing_o.h_act_start  = 10'(hfp_q) + 10'(hsw_q) + 10'(hbp_q);
    timing_o.h_act_end    = 12'(timing_o.h_act_start) + 12'(hact_q);
    h_total               = timing_o.h_act_end;
    // an empty line or frame counts as one tick long
    timing_o.h_last       = (h_total == '0) ? '0 : h_total - 12'd1;
    timing_o.v_sync_end   = vsw_q;
    timing_o.v_act_start  = 9'(vsw_q) + 9'(vbp_q);
    timing_o.v_act_end    = 12'(timing_o.v_act_start) + 12'(vact_q);
    v_total               = timing_o.v_act_end + 12'(vfp_q);
    timing_o.v_last       = (v_total == '0) ? '0 : v_total - 12'd1;
  end

endmodule

// ===== hdl/rptg_count.sv =====
// column and row counters and the input stage register
// depends on rptg_pkg
module rptg_count (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rptg_pkg::timing_t timing_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              red_i,
  input  logic              green_i,
  input  logic              blue_i,
  output logic              stage_valid_o,
  input  logic              stage_ready_i,
  output rptg_pkg::tick_t   stage_o
);

  logic [rptg_pkg::CntW-1:0] col_q, col_d, row_q, row_d;
  logic                      stage_valid_q, stage_valid_d;
  rptg_pkg::tick_t           stage_q, stage_d;
  logic                      accept, line_end, frame_end;

  assign in_ready_o = !stage_valid_q || stage_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // a counter left beyond the total by a register change wraps at once
  assign line_end  = col_q >= timing_i.h_last;
  assign frame_end = line_end && (row_q >= timing_i.v_last);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (line_end) begin
        col_d = '0;
        row_d = frame_end ? '0 : row_q + 12'd1;
      end else begin
        col_d = col_q + 12'd1;
      end
    end
    stage_valid_d = accept || (stage_valid_q && !stage_ready_i);
    stage_d       = stage_q;
    if (accept) begin
      stage_d.col       = col_q;
      stage_d.row       = row_q;
      stage_d.frame_end = frame_end;
      stage_d.red       = red_i;
      stage_d.green     = green_i;
      stage_d.blue      = blue_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q         <= '0;
      row_q         <= '0;
      stage_valid_q <= 1'b0;
    end else begin
      col_q         <= col_d;
      row_q         <= row_d;
      stage_valid_q <= stage_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stage_q <= stage_d;
  end

  assign stage_valid_o = stage_valid_q;
  assign stage_o       = stage_q;

endmodule

// ===== hdl/rptg_decode.sv =====
// region decode of a held tick and the result register
// depends on rptg_pkg
module rptg_decode (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rptg_pkg::timing_t timing_i,
  input  logic              stage_valid_i,
  output logic              stage_ready_o,
  input  rptg_pkg::tick_t   stage_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rptg_pkg::pixel_t  pixel_o
);

  logic             out_valid_q, out_valid_d;
  rptg_pkg::pixel_t pixel_q, pixel_d;
  logic             hs, vs, de, take;

  assign stage_ready_o = !out_valid_q || out_ready_i;
  assign take          = stage_valid_i && stage_ready_o;

  always_comb begin
    hs = (stage_i.col >= 12'(timing_i.h_sync_start)) &&
         (stage_i.col < 12'(timing_i.h_sync_end));
    vs = stage_i.row < 12'(timing_i.v_sync_end);
    de = (stage_i.col >= 12'(timing_i.h_act_start)) &&
         (stage_i.col < timing_i.h_act_end) &&
         (stage_i.row >= 12'(timing_i.v_act_start)) &&
         (stage_i.row < timing_i.v_act_end);

    pixel_d = pixel_q;
    if (take) begin
      pixel_d.hsync_n      = !hs;
      pixel_d.vsync_n      = !vs;
      pixel_d.data_enable  = de;
      pixel_d.red          = de && stage_i.red;
      pixel_d.green        = de && stage_i.green;
      pixel_d.blue         = de && stage_i.blue;
      pixel_d.pixel_strobe = 1'b1;
      pixel_d.frame_last   = stage_i.frame_end;
    end
    out_valid_d = take || (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pixel_q <= pixel_d;
  end

  assign out_valid_o = out_valid_q;
  assign pixel_o     = pixel_q;

endmodule

// ===== hdl/rgb_panel_timing_generator.sv =====
// Parallel RGB panel timing generator. Each input beat is one dot-clock tick carrying
// a pixel's red, green and blue bits; each tick yields exactly one output beat with
// active-low hsync/vsync, data enable, colour gated by data enable, a dot strobe and a
// frame-last flag. A line runs front porch, hsync pulse, back porch, active pixels; a
// frame runs vsync rows, back porch rows, active rows, front porch rows. The block
// takes one beat every clock cycle unless the output stalls: an accepted beat steps
// the column/row counters and its tick is held in the input stage register, and from
// there its regions are decoded into the result register that drives the outputs.
// Throughput is one tick per cycle while the output is not stalled; ready falls
// only when both stages are full and the output is stalled. Timing registers
// are written through the plain write port (index 0..7 in the order h_front_porch,
// h_sync_width, h_back_porch, h_active, v_sync_width, v_back_porch, v_active,
// v_front_porch) and must only be changed while no beats are in flight; a counter
// left beyond a shortened line or frame wraps to zero on its next tick.
// depends on rptg_pkg, rptg_regs, rptg_count, rptg_decode
module rgb_panel_timing_generator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [rptg_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rptg_pkg::CfgDataW-1:0] cfg_data_i,
  // input beats
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          red_in_i,
  input  logic                          green_in_i,
  input  logic                          blue_in_i,
  // output beats
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          hsync_n_o,
  output logic                          vsync_n_o,
  output logic                          data_enable_o,
  output logic                          red_out_o,
  output logic                          green_out_o,
  output logic                          blue_out_o,
  output logic                          pixel_strobe_o,
  output logic                          frame_last_o
);

  rptg_pkg::timing_t timing;
  rptg_pkg::tick_t   stage;
  rptg_pkg::pixel_t  pixel;
  logic              stage_valid, stage_ready;

  // timing registers and derived region edges
  rptg_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .timing_o   (timing)
  );

  // counters advance on every accepted beat; the tick is held with its position
  rptg_count u_count (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .timing_i      (timing),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .red_i         (red_in_i),
    .green_i       (green_in_i),
    .blue_i        (blue_in_i),
    .stage_valid_o (stage_valid),
    .stage_ready_i (stage_ready),
    .stage_o       (stage)
  );

  // region decode into the result register
  rptg_decode u_decode (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .timing_i      (timing),
    .stage_valid_i (stage_valid),
    .stage_ready_o (stage_ready),
    .stage_i       (stage),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_o       (pixel)
  );

  assign hsync_n_o      = pixel.hsync_n;
  assign vsync_n_o      = pixel.vsync_n;
  assign data_enable_o  = pixel.data_enable;
  assign red_out_o      = pixel.red;
  assign green_out_o    = pixel.green;
  assign blue_out_o     = pixel.blue;
  assign pixel_strobe_o = pixel.pixel_strobe;
  assign frame_last_o   = pixel.frame_last;

`ifndef SYNTHESIS
  // a held end-of-frame tick sits on the last column and last row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_valid && stage.frame_end |->
      (stage.col >= timing.h_last) && (stage.row >= timing.v_last))
    else $error("frame end flagged away from the last column and row");

  // a held tick stays put while the result register cannot take it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_valid && !stage_ready |=> stage_valid && $stable(stage))
    else $error("input stage lost or changed a stalled tick");

  // active pixels never overlap either sync pulse
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && data_enable_o |-> hsync_n_o && vsync_n_o)
    else $error("data enable during a sync pulse");
`endif

endmodule
